// ===== sv/iptp_pkg.sv =====
// shared types, constants and helpers for the ip address text parser
`default_nettype none

package iptp_pkg;

  localparam int unsigned NumGroups   = 8;
  localparam int unsigned GroupW      = 16;
  localparam int unsigned AddrW       = NumGroups * GroupW;
  localparam int unsigned CountW      = $clog2(NumGroups) + 1;

  localparam logic [9:0] OctetMax     = 10'd255;
  localparam logic [2:0] GroupDigits  = 3'd4;
  localparam logic [2:0] OctetDigits  = 3'd3;
  localparam logic [1:0] LastOctet    = 2'd3;
  localparam logic [2:0] RunSat       = 3'd7;

  localparam logic [1:0] ModeV4       = 2'd0;
  localparam logic [1:0] ModeV6       = 2'd1;

  localparam logic [7:0] ChNul        = 8'h00;
  localparam logic [7:0] ChColon      = 8'h3a;
  localparam logic [7:0] ChDot        = 8'h2e;

  typedef enum logic [1:0] {
    STATUS_REJECT = 2'd0,
    STATUS_ACCEPT = 2'd1,
    STATUS_UNSUP  = 2'd2
  } status_e;

  typedef logic [NumGroups-1:0][GroupW-1:0] grp_arr_t;

  typedef struct packed {
    logic [CountW-1:0] cnt;
    logic [CountW-1:0] gpos;
    logic              gap;
  } expand_ctl_t;

  typedef struct packed {
    logic       valid;
    logic       dec;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_of(logic [7:0] c);
    hex_t r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.valid = 1'b1;
      r.dec   = 1'b1;
      r.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      // a..f and A..F share the low nibble 1..6
      r.valid = 1'b1;
      r.value = 4'(c[3:0] + 4'd9);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/iptp_expand.sv =====
// zero gap expansion and group count check for the ipv6 result
`default_nettype none

module iptp_expand
  import iptp_pkg::*;
(
  input  grp_arr_t          head_i,
  input  logic [AddrW-1:0]  tail_i,
  input  expand_ctl_t       ctl_i,
  output logic              ok_o,
  output logic [AddrW-1:0]  addr_o
);

  logic bad;

  always_comb begin
    bad = 1'b0;
    if (ctl_i.cnt > CountW'(NumGroups)) bad = 1'b1;
    if (ctl_i.cnt < CountW'(NumGroups) && !ctl_i.gap) bad = 1'b1;
    if (ctl_i.cnt == CountW'(NumGroups) && ctl_i.gap) bad = 1'b1;
    if (ctl_i.gpos > ctl_i.cnt) bad = 1'b1;
  end

  assign ok_o = !bad;

  // groups after the gap sit right aligned in the tail, zeros above them
  always_comb begin
    for (int i = 0; i < NumGroups; i++) begin
      if (ctl_i.gap && CountW'(i) >= ctl_i.gpos) begin
        addr_o[AddrW-1-GroupW*i -: GroupW] = tail_i[AddrW-1-GroupW*i -: GroupW];
      end else begin
        addr_o[AddrW-1-GroupW*i -: GroupW] = head_i[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/ip_address_text_parser.sv =====
// top level of the streaming ip address text parser
// Usage: the address text enters one character per input word on in_character_i,
// with in_mode_i giving the family (0 ipv4, 1 ipv6, other unsupported); the
// mode is taken from the first word of each string. A zero character ends the
// string and produces exactly one output word (status, addr_high, addr_low);
// no other character produces output.
// Throughput: one character per cycle while in_stall_o is low. Each word is
// folded into the parse state in the cycle it is accepted; the terminator's
// result enters the output register at that edge and drives out_valid_o after it.
// Backpressure: while an output word waits under out_stall_i, non-terminator
// characters keep flowing; only a terminator is held off (in_stall_o) until the
// output register frees up, so no result is lost or overwritten.
// Reset: asynchronous, active low; the parser returns to string start and the
// output register empties. Address groups are held in an eight entry store that
// is written as groups complete; entries before the gap land at their position,
// those after it shift into a right aligned tail register.
`default_nettype none

module ip_address_text_parser
  import iptp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  in_mode_i,
  input  logic [7:0]  in_character_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_status_o,
  output logic [63:0] out_addr_high_o,
  output logic [63:0] out_addr_low_o
);

  typedef enum logic [2:0] {
    PH_START,
    PH_TOKEN,
    PH_FIRSTCOLON,
    PH_QUAD,
    PH_OTHER
  } phase_e;

  typedef enum logic [1:0] {
    FIN_REJECT,
    FIN_UNSUP,
    FIN_V4,
    FIN_V6
  } fin_e;

  typedef struct packed {
    logic [GroupW-1:0] hex;
    logic [9:0]        dec;
    logic [2:0]        rlen;
    logic              alldec;
  } run_t;

  localparam run_t RunClear = '{hex: '0, dec: '0, rlen: '0, alldec: 1'b1};

  function automatic run_t take_digit(run_t r, logic [3:0] h, logic dec);
    run_t n;
    n = r;
    n.hex = {r.hex[GroupW-5:0], h};
    if (!dec) begin
      n.alldec = 1'b0;
    end else if (r.rlen < OctetDigits) begin
      n.dec = 10'(r.dec * 10'd10 + 10'(h));
    end
    if (r.rlen < RunSat) n.rlen = 3'(r.rlen + 3'd1);
    return n;
  endfunction

  function automatic logic octet_ok(run_t r);
    return r.rlen >= 3'd1 && r.rlen <= OctetDigits && r.alldec && r.dec <= OctetMax;
  endfunction

  // parse state
  phase_e            phase_q, phase_w;
  run_t              run_q, run_w;
  logic [CountW-1:0] cnt_q, cnt_w;
  logic [CountW-1:0] gpos_q, gpos_w;
  logic              gap_q, gap_w;
  logic [1:0]        oct_q, oct_w;
  logic [31:0]       quad_q, quad_w;
  logic              err_q, err_w;
  logic [1:0]        fam_q, fam_w;
  grp_arr_t          head_q, head_w;
  logic [AddrW-1:0]  tail_q, tail_w;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [1:0]        status_q, status_d;
  logic [63:0]       high_q, high_d;
  logic [63:0]       low_q, low_d;

  logic              in_accept;
  logic              fin;
  fin_e              kind;
  hex_t              hx;
  logic              skip;
  logic [31:0]       qf;
  logic              exp_ok;
  logic [AddrW-1:0]  exp_addr;
  expand_ctl_t       exp_ctl;

  // only a terminator needs room in the output register
  assign in_stall_o = out_valid_q && out_stall_i && (in_character_i == ChNul);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign hx         = hex_of(in_character_i);

  always_comb begin
    phase_w = phase_q;
    run_w   = run_q;
    cnt_w   = cnt_q;
    gpos_w  = gpos_q;
    gap_w   = gap_q;
    oct_w   = oct_q;
    quad_w  = quad_q;
    err_w   = err_q;
    fam_w   = fam_q;
    head_w  = head_q;
    tail_w  = tail_q;
    fin     = 1'b0;
    kind    = FIN_REJECT;
    skip    = 1'b0;
    qf      = {quad_q[23:0], run_q.dec[7:0]};
    if (in_accept) begin
      if (phase_q == PH_START) begin
        run_w  = RunClear;
        cnt_w  = '0;
        gpos_w = '0;
        gap_w  = 1'b0;
        oct_w  = '0;
        quad_w = '0;
        err_w  = 1'b0;
        tail_w = '0;
        fam_w  = in_mode_i;
        if (in_mode_i == ModeV4) begin
          phase_w = PH_QUAD;
        end else if (in_mode_i == ModeV6) begin
          if (in_character_i == ChColon) begin
            phase_w = PH_FIRSTCOLON;
            skip    = 1'b1;
          end else begin
            phase_w = PH_TOKEN;
          end
        end else begin
          phase_w = PH_OTHER;
        end
      end
      qf = {quad_w[23:0], run_w.dec[7:0]};

      if (skip) begin
        // leading colon, the gap is formed by the next one
      end else if (in_character_i == ChNul) begin
        fin = 1'b1;
        priority if (err_w) begin
          kind = FIN_REJECT;
        end else if (phase_w == PH_OTHER) begin
          kind = FIN_UNSUP;
        end else if (phase_w == PH_QUAD) begin
          if (oct_w == LastOctet && octet_ok(run_w)) begin
            quad_w = qf;
            if (fam_w == ModeV4) begin
              kind = FIN_V4;
            end else if (cnt_w <= CountW'(NumGroups - 2)) begin
              if (gap_w) begin
                tail_w = {tail_w[AddrW-33:0], qf};
              end else begin
                head_w[cnt_w[CountW-2:0]]        = qf[31:16];
                head_w[cnt_w[CountW-2:0] + 1'b1] = qf[15:0];
              end
              cnt_w = CountW'(cnt_w + 2'd2);
              kind  = FIN_V6;
            end
          end
        end else if (phase_w == PH_TOKEN) begin
          if (run_w.rlen != '0) begin
            if (run_w.rlen > GroupDigits || cnt_w >= CountW'(NumGroups)) begin
              kind = FIN_REJECT;
            end else begin
              if (gap_w) tail_w = {tail_w[AddrW-GroupW-1:0], run_w.hex};
              else       head_w[cnt_w[CountW-2:0]] = run_w.hex;
              cnt_w = CountW'(cnt_w + 1'b1);
              kind  = FIN_V6;
            end
          end else begin
            kind = FIN_V6;
          end
        end else begin
          kind = FIN_REJECT;
        end
        phase_w = PH_START;
      end else if (!err_w && phase_w != PH_OTHER) begin
        unique case (phase_w)
          PH_FIRSTCOLON: begin
            if (in_character_i == ChColon) begin
              gap_w   = 1'b1;
              gpos_w  = '0;
              phase_w = PH_TOKEN;
            end else begin
              err_w = 1'b1;
            end
          end
          PH_TOKEN: begin
            if (run_w.rlen == '0 && cnt_w >= CountW'(NumGroups)) begin
              err_w = 1'b1;
            end else if (hx.valid) begin
              run_w = take_digit(run_w, hx.value, hx.dec);
            end else if (in_character_i == ChColon) begin
              if (run_w.rlen == '0) begin
                if (gap_w) begin
                  err_w = 1'b1;
                end else begin
                  gap_w  = 1'b1;
                  gpos_w = cnt_w;
                end
              end else if (run_w.rlen > GroupDigits) begin
                err_w = 1'b1;
              end else begin
                if (gap_w) tail_w = {tail_w[AddrW-GroupW-1:0], run_w.hex};
                else       head_w[cnt_w[CountW-2:0]] = run_w.hex;
                cnt_w = CountW'(cnt_w + 1'b1);
                run_w = RunClear;
              end
            end else if (in_character_i == ChDot) begin
              if (cnt_w > CountW'(NumGroups - 2) || !octet_ok(run_w)) begin
                err_w = 1'b1;
              end else begin
                quad_w  = qf;
                run_w   = RunClear;
                oct_w   = 2'd1;
                phase_w = PH_QUAD;
              end
            end else begin
              err_w = 1'b1;
            end
          end
          PH_QUAD: begin
            if (hx.valid && hx.dec) begin
              run_w = take_digit(run_w, hx.value, 1'b1);
            end else if (in_character_i == ChDot && oct_w < LastOctet && octet_ok(run_w)) begin
              quad_w = qf;
              run_w  = RunClear;
              oct_w  = 2'(oct_w + 1'b1);
            end else begin
              err_w = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign exp_ctl = '{cnt: cnt_w, gpos: gpos_w, gap: gap_w};

  iptp_expand u_expand (
    .head_i (head_w),
    .tail_i (tail_w),
    .ctl_i  (exp_ctl),
    .ok_o   (exp_ok),
    .addr_o (exp_addr)
  );

  always_comb begin
    status_d = status_q;
    high_d   = high_q;
    low_d    = low_q;
    if (fin) begin
      status_d = STATUS_REJECT;
      high_d   = '0;
      low_d    = '0;
      unique case (kind)
        FIN_UNSUP: status_d = STATUS_UNSUP;
        FIN_V4: begin
          status_d = STATUS_ACCEPT;
          low_d    = {32'd0, quad_w};
        end
        FIN_V6: begin
          if (exp_ok) begin
            status_d = STATUS_ACCEPT;
            high_d   = exp_addr[AddrW-1 -: 64];
            low_d    = exp_addr[63:0];
          end
        end
        default: status_d = STATUS_REJECT;
      endcase
    end
  end

  assign out_valid_d = fin || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      run_q       <= RunClear;
      cnt_q       <= '0;
      gpos_q      <= '0;
      gap_q       <= 1'b0;
      oct_q       <= '0;
      quad_q      <= '0;
      err_q       <= 1'b0;
      fam_q       <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_w;
      run_q       <= run_w;
      cnt_q       <= cnt_w;
      gpos_q      <= gpos_w;
      gap_q       <= gap_w;
      oct_q       <= oct_w;
      quad_q      <= quad_w;
      err_q       <= err_w;
      fam_q       <= fam_w;
      tail_q      <= tail_w;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q   <= head_w;
    status_q <= status_d;
    high_q   <= high_d;
    low_q    <= low_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_status_o    = status_q;
  assign out_addr_high_o = high_q;
  assign out_addr_low_o  = low_q;

endmodule

`default_nettype wire

// ===== verif/ip_address_text_parser_tb.sv =====
// self-checking testbench for the streaming ip address text parser
`default_nettype none

module ip_address_text_parser_tb
  import iptp_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ModeOther = 2'd2;
  localparam logic [1:0] ModeSpare = 2'd3;
  localparam int unsigned RandomChars = 1130;
  localparam int unsigned DrainCycles = 5000;

  typedef enum logic [2:0] {
    LX_START, LX_TOKEN, LX_FIRST_COLON, LX_QUAD, LX_OTHER
  } lex_e;

  typedef struct {
    status_e     status;
    logic [63:0] high;
    logic [63:0] low;
  } addr_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = 2'd0;
  logic [7:0]  in_char = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [63:0] out_addr_high;
  logic [63:0] out_addr_low;

  ip_address_text_parser u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .in_mode_i      (in_mode),
    .in_character_i (in_char),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_status_o   (out_status),
    .out_addr_high_o(out_addr_high),
    .out_addr_low_o (out_addr_low)
  );

  // parser shadow state
  logic [15:0] grp [NumGroups];
  logic [3:0]  grp_cnt;
  logic [3:0]  gap_pos;
  logic        gap_on;
  logic [15:0] run_hex;
  logic [9:0]  run_dec;
  logic [2:0]  run_len;
  logic        run_dec_only;
  logic [1:0]  oct_idx;
  logic [31:0] quad_acc;
  lex_e        lex = LX_START;
  logic        err;
  logic [1:0]  family = ModeV4;

  addr_result_t addr_expect_q[$];
  logic [7:0]   text_buf[$];

  int unsigned error_count = 0;
  int unsigned sent_chars = 0;
  int unsigned n_strings = 0;
  int unsigned n_accept = 0;
  int unsigned n_reject = 0;
  int unsigned n_unsup = 0;
  bit          calm = 1'b0;

  function automatic void clear_run();
    run_hex      = '0;
    run_dec      = '0;
    run_len      = '0;
    run_dec_only = 1'b1;
  endfunction

  function automatic void clear_string();
    for (int i = 0; i < NumGroups; i++) grp[i] = '0;
    grp_cnt  = '0;
    gap_pos  = '0;
    gap_on   = 1'b0;
    oct_idx  = '0;
    quad_acc = '0;
    err      = 1'b0;
    clear_run();
  endfunction

  // bit 4 flags a hex digit, low nibble is its value
  function automatic logic [4:0] nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - 8'h30)};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - 8'h61 + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - 8'h41 + 8'd10)};
    return 5'd0;
  endfunction

  function automatic void take_digit(logic [3:0] h, logic dec);
    run_hex = {run_hex[11:0], h};
    if (!dec) run_dec_only = 1'b0;
    else if (run_len < OctetDigits) run_dec = 10'(run_dec * 10 + h);
    if (run_len < RunSat) run_len = run_len + 3'd1;
  endfunction

  function automatic logic octet_ok();
    return run_len >= 3'd1 && run_len <= OctetDigits && run_dec_only
        && run_dec <= OctetMax;
  endfunction

  function automatic void push_octet();
    quad_acc = {quad_acc[23:0], run_dec[7:0]};
    clear_run();
  endfunction

  // fills the gap with zero groups and lays out all 128 bits
  function automatic logic expand_groups(output logic [63:0] hi, output logic [63:0] lo);
    int n;
    int z;
    int sh;
    logic [15:0]  g;
    logic [127:0] acc;
    n   = int'(grp_cnt);
    z   = int'(gap_pos);
    hi  = '0;
    lo  = '0;
    acc = '0;
    if (n > NumGroups) return 1'b0;
    if (n < NumGroups && !gap_on) return 1'b0;
    if (n == NumGroups && gap_on) return 1'b0;
    if (z > n) return 1'b0;
    sh = NumGroups - n;
    for (int i = 0; i < NumGroups; i++) begin
      if (!gap_on || i < z) g = grp[i];
      else if (i < z + sh) g = '0;
      else g = grp[i - sh];
      acc = {acc[111:0], g};
    end
    hi = acc[127:64];
    lo = acc[63:0];
    return 1'b1;
  endfunction

  function automatic void finish_string();
    addr_result_t r;
    logic [63:0]  hi;
    logic [63:0]  lo;
    logic         ok;
    r.status = STATUS_REJECT;
    hi = '0;
    lo = '0;
    if (err) begin
      r.status = STATUS_REJECT;
    end else if (lex == LX_OTHER) begin
      r.status = STATUS_UNSUP;
    end else if (lex == LX_QUAD) begin
      if (oct_idx == LastOctet && octet_ok()) begin
        push_octet();
        if (family == ModeV4) begin
          r.status = STATUS_ACCEPT;
          lo = {32'd0, quad_acc};
        end else if (grp_cnt + 2 <= NumGroups) begin
          grp[grp_cnt[2:0]]        = quad_acc[31:16];
          grp[3'(grp_cnt + 4'd1)]  = quad_acc[15:0];
          grp_cnt = grp_cnt + 4'd2;
          if (expand_groups(hi, lo)) r.status = STATUS_ACCEPT;
        end
      end
    end else if (lex == LX_TOKEN) begin
      ok = 1'b1;
      if (run_len > 0) begin
        if (run_len > GroupDigits || grp_cnt >= NumGroups) begin
          ok = 1'b0;
        end else begin
          grp[grp_cnt[2:0]] = run_hex;
          grp_cnt = grp_cnt + 4'd1;
        end
      end
      if (ok && expand_groups(hi, lo)) r.status = STATUS_ACCEPT;
    end
    if (r.status != STATUS_ACCEPT) begin
      hi = '0;
      lo = '0;
    end
    r.high = hi;
    r.low  = lo;
    addr_expect_q.push_back(r);
    n_strings++;
    case (r.status)
      STATUS_ACCEPT: n_accept++;
      STATUS_UNSUP:  n_unsup++;
      default:       n_reject++;
    endcase
    clear_string();
    lex = LX_START;
  endfunction

  // folds one accepted word into the shadow parser
  function automatic void parse_char(logic [1:0] m, logic [7:0] c);
    logic [4:0] nib;
    if (lex == LX_START) begin
      clear_string();
      family = m;
      if (m == ModeV4) begin
        lex = LX_QUAD;
      end else if (m == ModeV6) begin
        if (c == ChColon) begin
          lex = LX_FIRST_COLON;
          return;
        end
        lex = LX_TOKEN;
      end else begin
        lex = LX_OTHER;
      end
    end
    if (c == ChNul) begin
      finish_string();
      return;
    end
    if (err || lex == LX_OTHER) return;
    nib = nibble_of(c);
    case (lex)
      LX_FIRST_COLON: begin
        if (c == ChColon) begin
          gap_on  = 1'b1;
          gap_pos = '0;
          lex     = LX_TOKEN;
        end else begin
          err = 1'b1;
        end
      end
      LX_TOKEN: begin
        if (run_len == 0 && grp_cnt >= NumGroups) begin
          err = 1'b1;
        end else if (nib[4]) begin
          take_digit(nib[3:0], c >= "0" && c <= "9");
        end else if (c == ChColon) begin
          if (run_len == 0) begin
            if (gap_on) begin
              err = 1'b1;
            end else begin
              gap_on  = 1'b1;
              gap_pos = grp_cnt;
            end
          end else if (run_len > GroupDigits) begin
            err = 1'b1;
          end else begin
            grp[grp_cnt[2:0]] = run_hex;
            grp_cnt = grp_cnt + 4'd1;
            clear_run();
          end
        end else if (c == ChDot) begin
          if (grp_cnt + 2 > NumGroups || !octet_ok()) begin
            err = 1'b1;
          end else begin
            push_octet();
            oct_idx = 2'd1;
            lex     = LX_QUAD;
          end
        end else begin
          err = 1'b1;
        end
      end
      LX_QUAD: begin
        if (c >= "0" && c <= "9") begin
          take_digit(4'(c - 8'h30), 1'b1);
        end else if (c == ChDot && oct_idx < LastOctet && octet_ok()) begin
          push_octet();
          oct_idx = oct_idx + 2'd1;
        end else begin
          err = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("** ip_address_text_parser: FAILED **");
    $finish;
  end

  // result side back-pressure
  initial begin
    forever begin
      @(posedge clk);
      out_stall <= !calm && ($urandom_range(99) < 27);
    end
  end

  // compares each delivered word against the oldest expected address
  initial begin
    addr_result_t r;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall) begin
        if (addr_expect_q.size() == 0) begin
          $error("unexpected result word: status %0d", out_status);
          error_count++;
        end else begin
          r = addr_expect_q.pop_front();
          if (out_status !== r.status) begin
            $error("status: expected %0d, got %0d", r.status, out_status);
            error_count++;
          end
          if (out_addr_high !== r.high) begin
            $error("addr_high: expected %h, got %h", r.high, out_addr_high);
            error_count++;
          end
          if (out_addr_low !== r.low) begin
            $error("addr_low: expected %h, got %h", r.low, out_addr_low);
            error_count++;
          end
        end
      end
    end
  end

  task automatic send_char(input logic [1:0] m, input logic [7:0] c);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= m;
    in_char  <= c;
    do @(posedge clk); while (in_stall !== 1'b0);
    parse_char(m, c);
    sent_chars++;
  endtask

  // sends text_buf plus terminator; scrambled mode only matters on a string start
  task automatic send_buf(input logic [1:0] m, input bit scramble);
    logic [1:0] mi;
    logic [7:0] c;
    for (int i = 0; i <= text_buf.size(); i++) begin
      mi = (scramble && i > 0) ? 2'($urandom_range(3)) : m;
      c  = (i == text_buf.size()) ? ChNul : text_buf[i];
      send_char(mi, c);
    end
  endtask

  task automatic load_text(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic send_text(input logic [1:0] m, input string s);
    load_text(s);
    send_buf(m, 1'b0);
  endtask

  task automatic push_dec(input int v, input int w);
    int nd;
    nd = (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
    if (w < nd) w = nd;
    for (int k = w - 1; k >= 0; k--) text_buf.push_back(8'h30 + 8'((v / (10 ** k)) % 10));
  endtask

  task automatic push_group();
    int nd;
    int v;
    nd = ($urandom_range(19) == 0) ? 5 : $urandom_range(1, 4);
    for (int k = 0; k < nd; k++) begin
      v = $urandom_range(15);
      if (v < 10) text_buf.push_back(8'h30 + 8'(v));
      else if ($urandom_range(1)) text_buf.push_back(8'h41 + 8'(v - 10));
      else text_buf.push_back(8'h61 + 8'(v - 10));
    end
  endtask

  task automatic push_quad(input int parts);
    int v;
    for (int k = 0; k < parts; k++) begin
      if (k > 0) text_buf.push_back(ChDot);
      v = ($urandom_range(15) == 0) ? $urandom_range(256, 999) : $urandom_range(255);
      push_dec(v, ($urandom_range(19) == 0) ? 4 : $urandom_range(1, 3));
    end
  endtask

  task automatic build_v6();
    bit quad;
    bit gap;
    int slots;
    int total;
    int left;
    text_buf.delete();
    quad  = ($urandom_range(3) == 0);
    slots = quad ? 6 : 8;
    gap   = ($urandom_range(99) < 60);
    if (gap) begin
      total = ($urandom_range(9) == 0) ? slots : $urandom_range(slots - 1);
      left  = $urandom_range(total);
      for (int i = 0; i < left; i++) begin
        if (i > 0) text_buf.push_back(ChColon);
        push_group();
      end
      text_buf.push_back(ChColon);
      text_buf.push_back(ChColon);
      for (int i = 0; i < total - left; i++) begin
        if (i > 0) text_buf.push_back(ChColon);
        push_group();
      end
      if (quad) begin
        if (total - left > 0) text_buf.push_back(ChColon);
        push_quad(($urandom_range(9) == 0) ? 3 : 4);
      end
    end else begin
      total = ($urandom_range(9) == 0) ? $urandom_range(slots - 1, slots + 1) : slots;
      for (int i = 0; i < total; i++) begin
        if (i > 0) text_buf.push_back(ChColon);
        push_group();
      end
      if (quad) begin
        if (total > 0) text_buf.push_back(ChColon);
        push_quad(4);
      end
    end
    if (!quad && $urandom_range(99) < 8) text_buf.push_back(ChColon);
  endtask

  // corrupts a few strings by overwriting or inserting one character
  task automatic mangle_text();
    string punct;
    int    roll;
    punct = ":.9fG ";
    roll  = $urandom_range(99);
    if (text_buf.size() == 0) return;
    if (roll < 10) begin
      text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom_range(255));
    end else if (roll < 18) begin
      text_buf.insert($urandom_range(text_buf.size()),
                      punct[$urandom_range(punct.len() - 1)]);
    end
  endtask

  task automatic test_ipv4_forms();
    send_text(ModeV4, "255.255.255.255");
    send_text(ModeV4, "0.0.0.0");
    send_text(ModeV4, "001.02.3.004");
    send_text(ModeV4, "256.1.1.1");
    send_text(ModeV4, "1.2.3");
    send_text(ModeV4, "1.2.3.4.5");
    send_text(ModeV4, "");
    send_text(ModeV4, "1..2.3");
    // error mid string, rest is skipped
    send_text(ModeV4, "1.2.3.4a9.7");
    load_text("10.0.0.");
    text_buf.push_back(8'hff);
    send_buf(ModeV4, 1'b0);
  endtask

  task automatic test_ipv6_forms();
    send_text(ModeV6, "::");
    send_text(ModeV6, "1:2:3:4:5:6:7:8");
    send_text(ModeV6, "ffff:FFFF:abcd:ABCD:0:09af:F0e1:1234");
    send_text(ModeV6, "::ffff:192.168.0.1");
    send_text(ModeV6, "1:2:3:4:5:6:7:8:");
    send_text(ModeV6, "1:2:3:4:5:6:7:8:9");
    send_text(ModeV6, "1:2:3:4:5:6:7:1.2.3.4");
    send_text(ModeV6, "1:2:3:4:5:6:255.0.0.9");
    send_text(ModeV6, "1::2::3");
    send_text(ModeV6, ":1");
    send_text(ModeV6, "12345::");
    send_text(ModeV6, "1:2");
    send_text(ModeV6, "1::2:3:4:5:6:7:8");
    send_text(ModeV6, "::1.2.3");
    send_text(ModeV6, "");
    send_text(ModeV6, "fe80::1%g");
  endtask

  task automatic test_other_families();
    send_text(ModeOther, "1.2.3.4");
    send_text(ModeSpare, "::");
    send_text(ModeOther, "");
  endtask

  task automatic test_random_mix();
    int unsigned base;
    int unsigned done;
    int          kind;
    base = sent_chars;
    done = 0;
    while (done < RandomChars) begin
      // one quiet stretch with both sides streaming
      calm = (done > RandomChars * 2 / 5) && (done < RandomChars * 11 / 20);
      kind = $urandom_range(99);
      if (kind < 40) begin
        text_buf.delete();
        push_quad(($urandom_range(9) == 0) ? $urandom_range(3, 5) : 4);
        mangle_text();
        send_buf(ModeV4, 1'b1);
      end else if (kind < 85) begin
        build_v6();
        mangle_text();
        send_buf(ModeV6, 1'b1);
      end else if (kind < 90) begin
        load_text("1.2:ab");
        send_buf($urandom_range(1) ? ModeOther : ModeSpare, 1'b1);
      end else begin
        text_buf.delete();
        repeat ($urandom_range(1, 12)) text_buf.push_back(8'($urandom_range(1, 255)));
        send_buf(2'($urandom_range(3)), 1'b1);
      end
      done = sent_chars - base;
    end
    calm = 1'b0;
  endtask

  initial begin
    int unsigned waited;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ipv4_forms();
    test_ipv6_forms();
    test_other_families();
    test_random_mix();

    in_valid <= 1'b0;
    waited = 0;
    while (addr_expect_q.size() > 0 && waited < DrainCycles) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (addr_expect_q.size() > 0) begin
      $error("%0d expected results never arrived", addr_expect_q.size());
      error_count++;
    end

    $display("sent %0d characters forming %0d strings over ipv4, ipv6 and other families",
             sent_chars, n_strings);
    $display("predicted %0d accepted, %0d rejected, %0d unsupported; %0d mismatches",
             n_accept, n_reject, n_unsup, error_count);
    if (error_count == 0) begin
      $display("** ip_address_text_parser: PASSED **");
    end else begin
      $display("** ip_address_text_parser: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
sv/iptp_pkg.sv
sv/iptp_expand.sv
sv/ip_address_text_parser.sv
verif/ip_address_text_parser_tb.sv
